// ===== rtl/core/integer_to_ascii_padded_defines.svh =====
// Assertion macros used by the integer-to-ASCII formatter RTL.
`ifndef INTEGER_TO_ASCII_PADDED_DEFINES_SVH
`define INTEGER_TO_ASCII_PADDED_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ITOAP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ITOAP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/itoap_pkg.sv =====
// Package: constants, types and helper functions of the integer-to-ASCII formatter.
`timescale 1ns / 1ps
package itoap_pkg;

	localparam int MAX_WIDTH  = 32;
	localparam int NUM_DIGITS = 10;
	localparam int VAL_W      = 32;
	localparam int WID_W      = 6;
	localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
	localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
	localparam int LEN_W      = $clog2(NUM_DIGITS + 2);
	localparam int STEP_W     = $clog2(VAL_W);

	localparam logic [1:0] OP_SDEC = 2'd0;
	localparam logic [1:0] OP_UDEC = 2'd1;
	localparam logic [1:0] OP_LHEX = 2'd2;
	localparam logic [1:0] OP_UHEX = 2'd3;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;

	typedef logic [NUM_DIGITS-1:0][3:0] digit_vec_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic dec;
	} chain_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_LEAD,
		ST_PADL,
		ST_SIGN,
		ST_DIGIT,
		ST_PADR
	} fmt_state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UP_A : CH_LOW_A;
		if (d < 4'd10) begin
			digit_char = CH_ZERO + {4'd0, d};
		end else begin
			digit_char = base + {4'd0, d - 4'd10};
		end
	endfunction

endpackage

// ===== rtl/core/itoap_in_if.sv =====
// Request channel carrying one value to format with its conversion flags.
`timescale 1ns / 1ps
interface itoap_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic [1:0]  opcode;
	logic [5:0]  field_width;
	logic        left_justify;
	logic        zero_pad;

	modport source (output valid, value, opcode, field_width, left_justify, zero_pad,
		input ready);
	modport sink (input valid, value, opcode, field_width, left_justify, zero_pad,
		output ready);
endinterface

// ===== rtl/core/itoap_out_if.sv =====
// Character channel carrying one ASCII character and its end-of-field mark.
`timescale 1ns / 1ps
interface itoap_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;

	modport source (output valid, out_char, last, input ready);
	modport sink (input valid, out_char, last, output ready);
endinterface

// ===== rtl/core/itoap_cell.sv =====
// One digit cell: a 4-bit place that shifts in a bit per step, with add-3 fixup in decimal.
`timescale 1ns / 1ps
module itoap_cell (
	input  logic                  clk,
	input  itoap_pkg::chain_ctrl_t ctrl,
	input  logic                  bit_in,
	output logic                  carry_out,
	output logic [3:0]            digit
);
	import itoap_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Correct before the shift so the doubled digit carries into the next place.
	always_comb begin
		adj = digit_q;
		if (ctrl.dec && digit_q >= 4'd5) begin
			adj = digit_q + 4'd3;
		end
	end

	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.step) begin
			digit_q <= {adj[2:0], bit_in};
		end
	end
endmodule

// ===== rtl/core/itoap_chain.sv =====
// Row of digit cells fed by the magnitude shift register; reports the significant digit count.
`timescale 1ns / 1ps
module itoap_chain (
	input  logic                         clk,
	input  itoap_pkg::chain_ctrl_t       ctrl,
	input  logic [itoap_pkg::VAL_W-1:0]  mag,
	output itoap_pkg::digit_vec_t        digits,
	output logic [itoap_pkg::LEN_W-1:0]  ndig
);
	import itoap_pkg::*;

	logic [VAL_W-1:0]      mag_q;
	logic [NUM_DIGITS:0]   carry;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			mag_q <= mag;
		end else if (ctrl.step) begin
			mag_q <= {mag_q[VAL_W-2:0], 1'b0};
		end
	end

	assign carry[0] = mag_q[VAL_W-1];

	for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
		itoap_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.bit_in    (carry[g]),
			.carry_out (carry[g+1]),
			.digit     (digits[g])
		);
	end

	// Highest nonzero place sets the length; zero still prints one digit.
	always_comb begin
		ndig = LEN_W'(1);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (digits[i] != 4'd0) begin
				ndig = LEN_W'(i + 1);
			end
		end
	end

	logic unused_carry;
	assign unused_carry = carry[NUM_DIGITS];
endmodule

// ===== rtl/core/integer_to_ascii_padded.sv =====
// Conversion: after a request is accepted, the magnitude is shifted bit-serially through
// the digit cells, the field is sized, and then the first character is registered.
// Output: one character per cycle while chr.ready is high or the output register is empty;
// a new request is taken only when idle, after the last character of the field is emitted.
// Reset: arst_n clears the sequencer and the output valid; the block comes up idle.
`timescale 1ns / 1ps
`include "integer_to_ascii_padded_defines.svh"
module integer_to_ascii_padded (
	input logic         clk,
	input logic         arst_n,
	itoap_in_if.sink    item,
	itoap_out_if.source chr
);
	import itoap_pkg::*;

	fmt_state_t            state_q, state_d;
	logic [STEP_W-1:0]     bcnt_q, bcnt_d;
	logic [DIG_IDX_W-1:0]  dptr_q, dptr_d;
	logic [CNT_W-1:0]      pcnt_q, pcnt_d;
	logic [CNT_W-1:0]      rem_q, rem_d;
	logic [1:0]            op_q;
	logic [WID_W-1:0]      fw_q;
	logic                  lj_q, zp_q, neg_q, txtm_q, txtm_d;
	logic                  ov_q;
	logic [7:0]            ochar_q;
	logic                  olast_q;

	chain_ctrl_t           ctrl;
	digit_vec_t            digits;
	logic [LEN_W-1:0]      ndig;
	logic                  neg_in;
	logic [VAL_W-1:0]      mag_in;
	logic                  accept;

	logic                  out_load;
	logic                  emit;
	logic [7:0]            ch;
	logic [7:0]            padch;

	logic [CNT_W-1:0]      wsat, weff, pads, total, lentxt;
	logic                  lead;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign neg_in     = (item.opcode == OP_SDEC) && item.value[VAL_W-1];
	assign mag_in     = neg_in ? (VAL_W'(0) - item.value) : item.value;

	itoap_chain u_chain (
		.clk    (clk),
		.ctrl   (ctrl),
		.mag    (mag_in),
		.digits (digits),
		.ndig   (ndig)
	);

	// Field sizing from the converted digits.
	always_comb begin
		wsat   = (int'(fw_q) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(fw_q);
		lead   = neg_q && (wsat != '0) && zp_q;
		weff   = wsat - CNT_W'(lead);
		txtm_d = neg_q && !lead;
		lentxt = CNT_W'(ndig) + CNT_W'(txtm_d);
		pads   = (weff > lentxt) ? (weff - lentxt) : '0;
		total  = CNT_W'(lead) + pads + lentxt;
	end

	assign padch    = zp_q ? CH_ZERO : CH_SPACE;
	assign out_load = !ov_q || chr.ready;

	always_comb begin
		state_d    = state_q;
		bcnt_d     = bcnt_q;
		dptr_d     = dptr_q;
		pcnt_d     = pcnt_q;
		rem_d      = rem_q;
		ctrl       = '0;
		ctrl.dec   = !op_q[1];
		emit       = 1'b0;
		ch         = CH_SPACE;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctrl.clear = 1'b1;
					bcnt_d     = '0;
					state_d    = ST_CONV;
				end
			end
			ST_CONV: begin
				ctrl.step = 1'b1;
				bcnt_d    = bcnt_q + 1'b1;
				if (bcnt_q == STEP_W'(VAL_W - 1)) begin
					state_d = ST_SIZE;
				end
			end
			ST_SIZE: begin
				dptr_d = DIG_IDX_W'(ndig - 1'b1);
				pcnt_d = pads;
				rem_d  = total;
				if (lead) begin
					state_d = ST_LEAD;
				end else if (pads != '0 && !lj_q) begin
					state_d = ST_PADL;
				end else if (txtm_d) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_DIGIT;
				end
			end
			ST_LEAD: begin
				ch = CH_MINUS;
				if (out_load) begin
					emit = 1'b1;
					if (pcnt_q != '0 && !lj_q) begin
						state_d = ST_PADL;
					end else begin
						state_d = ST_DIGIT;
					end
				end
			end
			ST_PADL: begin
				ch = padch;
				if (out_load) begin
					emit   = 1'b1;
					pcnt_d = pcnt_q - 1'b1;
					if (pcnt_q == CNT_W'(1)) begin
						state_d = txtm_q ? ST_SIGN : ST_DIGIT;
					end
				end
			end
			ST_SIGN: begin
				ch = CH_MINUS;
				if (out_load) begin
					emit    = 1'b1;
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				ch = digit_char(digits[dptr_q], op_q == OP_UHEX);
				if (out_load) begin
					emit = 1'b1;
					if (dptr_q == '0) begin
						state_d = (pcnt_q != '0 && lj_q) ? ST_PADR : ST_IDLE;
					end else begin
						dptr_d = dptr_q - 1'b1;
					end
				end
			end
			ST_PADR: begin
				ch = padch;
				if (out_load) begin
					emit   = 1'b1;
					pcnt_d = pcnt_q - 1'b1;
					if (pcnt_q == CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (emit) begin
			rem_d = rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bcnt_q  <= '0;
			dptr_q  <= '0;
			pcnt_q  <= '0;
			rem_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			bcnt_q  <= bcnt_d;
			dptr_q  <= dptr_d;
			pcnt_q  <= pcnt_d;
			rem_q   <= rem_d;
			if (out_load) begin
				ov_q <= emit;
			end
		end
	end

	// Request fields and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= item.opcode;
			fw_q  <= item.field_width;
			lj_q  <= item.left_justify;
			zp_q  <= item.zero_pad;
			neg_q <= neg_in;
		end
		if (state_q == ST_SIZE) begin
			txtm_q <= txtm_d;
		end
		if (out_load && emit) begin
			ochar_q <= ch;
			olast_q <= (rem_q == CNT_W'(1));
		end
	end

	assign chr.valid    = ov_q;
	assign chr.out_char = ochar_q;
	assign chr.last     = olast_q;

	`ITOAP_ASSERT_NEXT(a_accept_starts_conv, accept, state_q == ST_CONV, "accept did not start conversion")
	`ITOAP_ASSERT_NOW(a_idle_no_remaining, state_q == ST_IDLE, rem_q == '0, "idle with characters left")
	`ITOAP_ASSERT_NEXT(a_last_ends_field, emit && rem_q == CNT_W'(1), state_q == ST_IDLE, "last char did not end field")
	`ITOAP_ASSERT_NOW(a_emit_counts, emit, rem_q != '0, "character emitted beyond field length")
	`ITOAP_ASSERT_NOW(a_digit_ptr_range, state_q == ST_DIGIT, int'(dptr_q) < NUM_DIGITS, "digit pointer out of range")
endmodule
